@@ rtl/s2rd_pkg.sv @@
// Shared types and constants for the signed integer to radix digits unit.
package s2rd_pkg;

   // Alphabet register file: eight 64-bit words, eight symbols each
   localparam int NUM_WORDS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int WORD_IDX_W  = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int SYM_IDX_W   = 6;

   // Quotient bits resolved per divide cycle
   localparam int DIV_STEP_BITS = 8;

   localparam logic [WORD_BITS-1:0] ALPHA_WORD0_RESET = 64'h3736353433323130;
   localparam logic [WORD_BITS-1:0] ALPHA_WORD1_RESET = 64'h0000000000003938;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOW   = 8'd32;
   localparam logic [7:0] CHAR_HIGH  = 8'd126;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef logic [SYM_IDX_W-1:0]  sym_idx_type;
   typedef logic [WORD_BITS-1:0]  word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/signed_int_to_radix_digits_unit.sv @@
// Signed integer to text converter in a programmable radix, one character per transaction.

// Each input transaction carries one signed VALUE_BITS number; the unit returns its text
// one character per output transaction, most significant digit first, with a leading '-'
// for negatives and last set on the final character. The digit symbols are an alphabet
// packed eight bytes per CSR word (lowest byte first) and ended by the first zero byte;
// the radix is the alphabet length. An alphabet shorter than two symbols, or holding '+',
// '-', space, a byte outside 32..126 or a repeated symbol, makes every number produce no
// output at all. The unit works on one number at a time and req_ready is high only while
// it is idle. After reset or any CSR write the first number pays an alphabet check, one
// symbol per cycle through a single read mux. Each digit then passes the shared divider,
// which resolves eight quotient bits per cycle, and characters leave the output register
// one per cycle while the consumer keeps rsp_ready high. The final character can still be
// leaving the unit while the next number is taken.
module signed_int_to_radix_digits_unit #(
   parameter int ALPHABET_MAX = 64,
   parameter int VALUE_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input number channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [VALUE_BITS-1:0]         req_value,
   // output character channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_symbol,
   output logic                                 rsp_last,
   // alphabet CSR write port
   input  logic                                 csr_wr_en,
   input  logic [s2rd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [s2rd_pkg::WORD_BITS-1:0]       csr_wdata
);

   // digit width, radix width, divider geometry, digit stack depth counter
   localparam int DW         = (ALPHABET_MAX > 2) ? $clog2(ALPHABET_MAX) : 1;
   localparam int RW         = $clog2(ALPHABET_MAX + 1);
   localparam int CW         = DW + 1;
   localparam int DIV_CYCLES = (VALUE_BITS + s2rd_pkg::DIV_STEP_BITS - 1)
                               / s2rd_pkg::DIV_STEP_BITS;
   localparam int QW         = DIV_CYCLES * s2rd_pkg::DIV_STEP_BITS;
   localparam int DCW        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int DPW        = $clog2(VALUE_BITS + 1);

   localparam logic [VALUE_BITS-1:0] VAL_ONE  = VALUE_BITS'(1);
   localparam logic [RW-1:0]         RAD_MAX  = RW'(ALPHABET_MAX);
   localparam logic [RW-1:0]         RAD_MIN  = RW'(2);
   localparam logic [DCW-1:0]        DIV_LAST = DCW'(DIV_CYCLES - 1);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   s2rd_pkg::state_type                           state_ff, state_in;
   logic [s2rd_pkg::NUM_WORDS-1:0][s2rd_pkg::WORD_BITS-1:0] alpha_ff;

   logic              checked_ff, checked_in;   // alphabet verified since last CSR write
   logic              ok_ff, ok_in;             // verified alphabet is usable
   logic [RW-1:0]     radix_ff, radix_in;
   logic [RW-1:0]     cnt_ff, cnt_in;           // scan position
   logic [127:0]      seen_ff, seen_in;         // symbols met so far in the scan

   logic [QW-1:0]     dq_ff, dq_in;             // dividend, becomes quotient
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DCW-1:0]    div_cnt_ff, div_cnt_in;
   logic              sign_ff, sign_in;         // '-' still owed

   logic [DW-1:0]     stk_ff [VALUE_BITS];      // digit stack, top at entry 0
   logic [DPW-1:0]    depth_ff, depth_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_symbol_ff, rsp_symbol_in;
   logic              rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------------
   // Alphabet read mux: one port, shared by the scan and the emit phase
   // ------------------------------------------------------------------
   s2rd_pkg::sym_idx_type rd_idx;
   s2rd_pkg::word_type    rd_word;
   logic [7:0]            rd_sym;

   assign rd_idx  = (state_ff == s2rd_pkg::ST_SCAN) ? s2rd_pkg::sym_idx_type'(cnt_ff)
                                                    : s2rd_pkg::sym_idx_type'(stk_ff[0]);
   assign rd_word = alpha_ff[rd_idx[s2rd_pkg::SYM_IDX_W-1:3]];
   assign rd_sym  = rd_word[{rd_idx[2:0], 3'b000} +: 8];

   logic scan_end, scan_bad;
   assign scan_end = (cnt_ff == RAD_MAX) || (rd_sym == s2rd_pkg::CHAR_NUL);
   assign scan_bad = (rd_sym == s2rd_pkg::CHAR_PLUS) || (rd_sym == s2rd_pkg::CHAR_MINUS)
                  || (rd_sym == s2rd_pkg::CHAR_SPACE) || (rd_sym < s2rd_pkg::CHAR_LOW)
                  || (rd_sym > s2rd_pkg::CHAR_HIGH) || seen_ff[rd_sym[6:0]];

   // ------------------------------------------------------------------
   // Input magnitude
   // ------------------------------------------------------------------
   logic [VALUE_BITS-1:0] val_u, mag;
   logic                  neg;

   assign val_u = req_value;
   assign neg   = val_u[VALUE_BITS-1];
   assign mag   = neg ? (~val_u + VAL_ONE) : val_u;

   // ------------------------------------------------------------------
   // Shared divider: eight restoring steps per cycle on a narrow remainder
   // ------------------------------------------------------------------
   logic [QW-1:0] dq_nxt;
   logic [DW-1:0] rem_nxt;

   always_comb begin
      logic [CW-1:0] t;
      logic [CW-1:0] rad;
      logic [DW-1:0] r;
      logic [QW-1:0] d;
      rad = CW'(radix_ff);
      r   = rem_ff;
      d   = dq_ff;
      for (int s = 0; s < s2rd_pkg::DIV_STEP_BITS; s++) begin
         t = {r, d[QW-1]};
         d = {d[QW-2:0], 1'b0};
         if (t >= rad) begin
            t    = t - rad;
            d[0] = 1'b1;
         end
         r = t[DW-1:0];
      end
      dq_nxt  = d;
      rem_nxt = r;
   end

   // ------------------------------------------------------------------
   // Sequencer: next state and datapath controls
   // ------------------------------------------------------------------
   logic push, pop;

   always_comb begin
      state_in      = state_ff;
      checked_in    = checked_ff;
      ok_in         = ok_ff;
      radix_in      = radix_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      sign_in       = sign_ff;
      depth_in      = depth_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      push          = 1'b0;
      pop           = 1'b0;

      // drop the output character once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // a new alphabet must be verified again
      if (csr_wr_en) begin
         checked_in = 1'b0;
      end

      unique case (state_ff)
         s2rd_pkg::ST_IDLE: begin
            if (req_valid) begin
               sign_in    = neg;
               dq_in      = QW'(mag);
               rem_in     = '0;
               div_cnt_in = '0;
               depth_in   = '0;
               if (!checked_ff) begin
                  cnt_in   = '0;
                  seen_in  = '0;
                  state_in = s2rd_pkg::ST_SCAN;
               end else if (ok_ff) begin
                  state_in = s2rd_pkg::ST_DIVIDE;
               end
            end
         end

         s2rd_pkg::ST_SCAN: begin
            if (scan_end) begin
               radix_in   = cnt_ff;
               ok_in      = (cnt_ff >= RAD_MIN);
               checked_in = 1'b1;
               state_in   = (cnt_ff >= RAD_MIN) ? s2rd_pkg::ST_DIVIDE : s2rd_pkg::ST_IDLE;
            end else if (scan_bad) begin
               ok_in      = 1'b0;
               checked_in = 1'b1;
               state_in   = s2rd_pkg::ST_IDLE;
            end else begin
               seen_in[rd_sym[6:0]] = 1'b1;
               cnt_in               = RW'(cnt_ff + 1'b1);
            end
         end

         s2rd_pkg::ST_DIVIDE: begin
            dq_in      = dq_nxt;
            rem_in     = rem_nxt;
            div_cnt_in = DCW'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == DIV_LAST) begin
               // one digit done: push it, restart on the quotient
               push       = 1'b1;
               depth_in   = DPW'(depth_ff + 1'b1);
               rem_in     = '0;
               div_cnt_in = '0;
               if (dq_nxt == '0) begin
                  state_in = s2rd_pkg::ST_EMIT;
               end
            end
         end

         s2rd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_symbol_in = s2rd_pkg::CHAR_MINUS;
                  rsp_last_in   = 1'b0;
                  sign_in       = 1'b0;
               end else begin
                  rsp_symbol_in = rd_sym;
                  rsp_last_in   = (depth_ff == DPW'(1));
                  pop           = 1'b1;
                  depth_in      = DPW'(depth_ff - 1'b1);
                  if (depth_ff == DPW'(1)) begin
                     state_in = s2rd_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = s2rd_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // State and control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= s2rd_pkg::ST_IDLE;
         checked_ff   <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         depth_ff     <= '0;
         div_cnt_ff   <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         checked_ff   <= checked_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         depth_ff     <= depth_in;
         div_cnt_ff   <= div_cnt_in;
         cnt_ff       <= cnt_in;
      end
   end

   // alphabet CSRs; writes past the last word are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= {{((s2rd_pkg::NUM_WORDS - 2) * s2rd_pkg::WORD_BITS){1'b0}},
                      s2rd_pkg::ALPHA_WORD1_RESET, s2rd_pkg::ALPHA_WORD0_RESET};
      end else if (csr_wr_en && (csr_index < s2rd_pkg::CSR_INDEX_W'(s2rd_pkg::NUM_WORDS))) begin
         alpha_ff[csr_index[s2rd_pkg::WORD_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      radix_ff      <= radix_in;
      seen_ff       <= seen_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // digit stack: push the newest (more significant) digit on top, pop from the top
   always_ff @(posedge clock) begin
      if (push) begin
         stk_ff[0] <= rem_nxt;
         for (int k = 1; k < VALUE_BITS; k++) begin
            stk_ff[k] <= stk_ff[k-1];
         end
      end else if (pop) begin
         for (int k = 0; k < VALUE_BITS - 1; k++) begin
            stk_ff[k] <= stk_ff[k+1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------
   assign req_ready  = (state_ff == s2rd_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the signed integer to radix digits unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W      = 32;
   localparam int ALPHA_MAX    = 64;
   // Worst number: alphabet check, 32 digits through the divider, 33 characters out
   localparam int QUIET_CYCLES = 250;
   localparam int CYCLE_LIMIT  = 1000000;

   // One character of a number's text
   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } text_char_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [VALUE_W-1:0]           req_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [7:0]                          rsp_symbol;
   logic                                rsp_last;
   logic                                csr_wr_en;
   logic [s2rd_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [s2rd_pkg::WORD_BITS-1:0]      csr_wdata;

   // Mirror of the alphabet registers, updated on every write edge
   s2rd_pkg::word_type alpha_words [s2rd_pkg::NUM_WORDS];
   // Alphabet under construction, and its packed form ready to load
   logic [7:0]         new_syms [$];
   s2rd_pkg::word_type next_words [s2rd_pkg::NUM_WORDS];
   // Characters predicted but not yet seen on the output channel
   text_char_type      pending_chars [$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int          hold_left;
   int          mismatch_count;
   int          numbers_sent;
   int          chars_checked;
   int          alphabet_loads;
   int          cycle_count;

   signed_int_to_radix_digits_unit #(
      .ALPHABET_MAX (ALPHA_MAX),
      .VALUE_BITS   (VALUE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock: low half then high half
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Bound the run; a hang counts as a failure
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters still pending",
                  cycle_count, pending_chars.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: stall at random, or hold off completely while hold_left runs down
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Checker: compare each accepted character with the oldest prediction
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_checked = chars_checked + 1;
         if (pending_chars.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: unexpected character: expected none, got symbol %h last %b",
                     $time, rsp_symbol, rsp_last);
         end else begin
            want = pending_chars.pop_front();
            if (want.symbol !== rsp_symbol || want.last !== rsp_last) begin
               mismatch_count = mismatch_count + 1;
               $display({"%0t: character mismatch: expected symbol %h last %b, ",
                         "got symbol %h last %b"},
                        $time, want.symbol, want.last, rsp_symbol, rsp_last);
            end
         end
      end
   end

   // Work out the text of one number under the current alphabet and queue it.
   // A bad alphabet (too short, a sign, space, non-printable, or repeated symbol)
   // yields no text at all.
   function automatic void predict_text(input logic [VALUE_W-1:0] v);
      logic [7:0]          syms [ALPHA_MAX];
      logic [7:0]          c;
      logic [7:0]          digits [$];
      logic [VALUE_W-1:0]  mag;
      int unsigned         len;
      bit                  usable;
      text_char_type       ch;
      len = 0;
      while (len < ALPHA_MAX) begin
         c = alpha_words[len / 8][(len % 8) * 8 +: 8];
         if (c == s2rd_pkg::CHAR_NUL) break;
         syms[len] = c;
         len++;
      end
      usable = (len >= 2);
      for (int i = 0; i < len; i++) begin
         c = syms[i];
         if (c == s2rd_pkg::CHAR_PLUS || c == s2rd_pkg::CHAR_MINUS ||
             c == s2rd_pkg::CHAR_SPACE || c < s2rd_pkg::CHAR_LOW || c > s2rd_pkg::CHAR_HIGH)
            usable = 1'b0;
         for (int j = i + 1; j < len; j++)
            if (syms[j] == c) usable = 1'b0;
      end
      if (!usable) return;
      // Two's complement magnitude; the most negative value maps to 2^31 unsigned
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      do begin
         digits.push_front(syms[mag % len]);
         mag = mag / len;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
         ch.symbol = s2rd_pkg::CHAR_MINUS;
         ch.last   = 1'b0;
         pending_chars.push_back(ch);
      end
      for (int k = 0; k < digits.size(); k++) begin
         ch.symbol = digits[k];
         ch.last   = (k == digits.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   // Mix of small magnitudes, extremes and full-range values
   function automatic logic signed [VALUE_W-1:0] rand_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            v = $urandom_range(0, 300);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         3: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = -1;
               2: v = 1;
               3: v = 32'sh7FFFFFFF;
               default: v = 32'sh80000000;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Offer one number; entered and left at a falling edge with valid still high,
   // so back-to-back transactions never drop valid in between.
   task automatic send_value(input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      do @(posedge clock); while (!req_ready);
      predict_text(v);
      numbers_sent = numbers_sent + 1;
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted character, then let the unit go quiet
   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // One register write; leaves the write enable high for a following write
   task automatic write_csr(input int idx, input s2rd_pkg::word_type data);
      csr_wr_en = 1'b1;
      csr_index = idx[s2rd_pkg::CSR_INDEX_W-1:0];
      csr_wdata = data;
      @(posedge clock);
      if (idx < s2rd_pkg::NUM_WORDS) alpha_words[idx] = data;
      @(negedge clock);
   endtask

   // Pack new_syms into words; with junk_tail, fill bytes past the terminator
   // with random data that must never be read as symbols.
   task automatic pack_and_load(input bit junk_tail);
      for (int w = 0; w < s2rd_pkg::NUM_WORDS; w++) next_words[w] = '0;
      for (int i = 0; i < new_syms.size() && i < ALPHA_MAX; i++)
         next_words[i / 8][(i % 8) * 8 +: 8] = new_syms[i];
      if (junk_tail)
         for (int i = new_syms.size() + 1; i < ALPHA_MAX; i++)
            next_words[i / 8][(i % 8) * 8 +: 8] = 8'($urandom_range(0, 255));
      wait_drain();
      for (int w = 0; w < s2rd_pkg::NUM_WORDS; w++) write_csr(w, next_words[w]);
      csr_wr_en = 1'b0;
      alphabet_loads = alphabet_loads + 1;
   endtask

   task automatic from_text(input string s);
      new_syms.delete();
      for (int i = 0; i < s.len(); i++) new_syms.push_back(s[i]);
   endtask

   // Draw n distinct legal symbols in random order
   task automatic pick_alphabet(input int n);
      logic [7:0] pool [$];
      int         k;
      new_syms.delete();
      for (int c = 33; c <= 126; c++)
         if (c != s2rd_pkg::CHAR_PLUS && c != s2rd_pkg::CHAR_MINUS) pool.push_back(8'(c));
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, pool.size() - 1);
         new_syms.push_back(pool[k]);
         pool.delete(k);
      end
   endtask

   // Reset alphabet is decimal: zero, sign handling and both ends of the range
   task automatic test_decimal_reset();
      send_value(0);
      send_value(7);
      send_value(-7);
      send_value(10);
      send_value(32'sh7FFFFFFF);
      send_value(32'sh80000000);
      send_value(-1);
   endtask

   // Smallest and largest radix, plus hex
   task automatic test_alphabet_extremes();
      from_text("01");
      pack_and_load(1'b0);
      send_value(32'sh80000000);   // longest text: sign plus 32 digits
      send_value(32'sh7FFFFFFF);
      send_value(32'sh55555555);
      from_text("0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz@#");
      pack_and_load(1'b0);
      send_value(32'sh80000000);
      send_value(63);
      send_value(-64);
      from_text("0123456789ABCDEF");
      pack_and_load(1'b1);
      send_value(32'shAAAAAAAA);
      send_value(32'sh12345678);
   endtask

   // Every way an alphabet can be rejected; each number must yield nothing
   task automatic test_invalid_alphabets();
      for (int kind = 0; kind < 9; kind++) begin
         case (kind)
            0: new_syms.delete();
            1: from_text("7");
            2: from_text("01+");
            3: from_text("0-1");
            4: from_text("0 1");
            5: begin from_text("01"); new_syms.push_back(8'h1F); end
            6: begin from_text("01"); new_syms.push_back(8'h7F); end
            7: begin from_text("01"); new_syms.push_back(8'hFF); end
            default: from_text("0120");
         endcase
         pack_and_load(1'b0);
         send_value(rand_value());
      end
   endtask

   // Writes to indexes past the last alphabet word must not disturb it
   task automatic test_ignored_index();
      from_text("0123456789");
      pack_and_load(1'b0);
      write_csr(8, 64'h2B2D2020_2B2D2020);
      write_csr(15, '0);
      csr_wr_en = 1'b0;
      send_value(-12345);
      send_value(908);
   endtask

   // Random alphabets and numbers across the idling mixes
   task automatic test_random_traffic();
      int len;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         for (int a = 0; a < 2; a++) begin
            case ($urandom_range(0, 7))
               0: len = 2;
               1: len = ALPHA_MAX;
               2, 3: len = $urandom_range(17, ALPHA_MAX - 1);
               default: len = $urandom_range(3, 16);
            endcase
            pick_alphabet(len);
            pack_and_load($urandom_range(0, 1));
            repeat (20) send_value(rand_value());
         end
      end
   endtask

   // Corrupt an otherwise good alphabet in one random way; numbers are dropped
   task automatic test_broken_alphabets();
      int pos;
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      repeat (6) begin
         pick_alphabet($urandom_range(3, 20));
         pos = $urandom_range(0, new_syms.size() - 1);
         case ($urandom_range(0, 6))
            0: new_syms[pos] = s2rd_pkg::CHAR_PLUS;
            1: new_syms[pos] = s2rd_pkg::CHAR_MINUS;
            2: new_syms[pos] = s2rd_pkg::CHAR_SPACE;
            3: new_syms[pos] = 8'($urandom_range(1, 31));
            4: new_syms[pos] = 8'($urandom_range(127, 255));
            5: begin
               pos = $urandom_range(1, new_syms.size() - 1);
               new_syms[pos] = new_syms[$urandom_range(0, pos - 1)];
            end
            default: new_syms = new_syms[0:0];
         endcase
         pack_and_load($urandom_range(0, 1));
         repeat (3) send_value(rand_value());
      end
   endtask

   // Hold the receiver off while numbers keep coming so the input stalls,
   // then pause the sender until all text is out and carry on.
   task automatic test_backpressure();
      pick_alphabet(8);
      pack_and_load(1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 400;
      repeat (6) send_value(rand_value());
      wait_drain();
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      repeat (10) send_value(rand_value());
   endtask

   initial begin
      // Known values on every input before the first edge
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      mismatch_count = 0;
      numbers_sent   = 0;
      chars_checked  = 0;
      alphabet_loads = 0;
      cycle_count    = 0;
      for (int w = 0; w < s2rd_pkg::NUM_WORDS; w++) alpha_words[w] = '0;
      alpha_words[0] = s2rd_pkg::ALPHA_WORD0_RESET;
      alpha_words[1] = s2rd_pkg::ALPHA_WORD1_RESET;

      // Hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_decimal_reset();
      test_alphabet_extremes();
      test_invalid_alphabets();
      test_ignored_index();
      test_random_traffic();
      test_broken_alphabets();
      test_backpressure();
      wait_drain();

      $display("Converted %0d numbers into %0d checked characters over %0d alphabet loads,",
               numbers_sent, chars_checked, alphabet_loads);
      $display("radix 2 to 64, rejected alphabets, stray register writes and output hold-off.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/s2rd_pkg.sv
rtl/signed_int_to_radix_digits_unit.sv
dv/tb_top.sv
